// ===== rtl/rar_pkg.sv =====
// ============================================================================
// rar_pkg
// Shared operation codes, result width and control struct for the rational
// arithmetic block.
// ============================================================================
`default_nettype none

package rar_pkg;

    localparam int RESULT_WIDTH = 33;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Decoded operation, carried from the front end to the back end.
    typedef struct packed {
        logic p0_rn;   // first numerator product uses rhs_num instead of rhs_den
        logic p1_en;   // second numerator product is used
        logic p1_sub;  // second numerator product is subtracted
        logic den_rn;  // denominator product uses rhs_num instead of rhs_den
    } rar_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/rar_if.sv =====
// ============================================================================
// rar_if
// Valid/ready channels for operand beats and result beats.
// ============================================================================
`default_nettype none

interface rar_in_if #(parameter int OPERAND_WIDTH = 16);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      action;
    logic signed [OPERAND_WIDTH-1:0] lhs_num;
    logic signed [OPERAND_WIDTH-1:0] lhs_den;
    logic signed [OPERAND_WIDTH-1:0] rhs_num;
    logic signed [OPERAND_WIDTH-1:0] rhs_den;

    modport source (output valid, action, lhs_num, lhs_den, rhs_num, rhs_den,
                    input ready);
    modport sink   (input valid, action, lhs_num, lhs_den, rhs_num, rhs_den,
                    output ready);
endinterface

interface rar_out_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] result_num;
    logic signed [32:0] result_den;
    logic               zero_denominator;

    modport source (output valid, result_num, result_den, zero_denominator,
                    input ready);
    modport sink   (input valid, result_num, result_den, zero_denominator,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/rar_front.sv =====
// ============================================================================
// rar_front
// Accepts operand beats, decodes the operation and holds them in a two-entry
// queue for the back end.
// ============================================================================
`default_nettype none

module rar_front
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    rar_in_if.sink                               in_ch,
    output logic                                 q_valid,
    input  wire logic                            q_ready,
    output rar_ctrl_t                            q_ctrl,
    output logic signed [OPERAND_WIDTH-1:0]      q_ln,
    output logic signed [OPERAND_WIDTH-1:0]      q_ld,
    output logic signed [OPERAND_WIDTH-1:0]      q_rn,
    output logic signed [OPERAND_WIDTH-1:0]      q_rd
);

    localparam int QD = 2;
    localparam int PW = $clog2(QD);
    localparam int CW = $clog2(QD + 1);

    rar_ctrl_t                       ctrl_q [QD];
    logic signed [OPERAND_WIDTH-1:0] ln_q [QD];
    logic signed [OPERAND_WIDTH-1:0] ld_q [QD];
    logic signed [OPERAND_WIDTH-1:0] rn_q [QD];
    logic signed [OPERAND_WIDTH-1:0] rd_q [QD];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push, pop;
    rar_ctrl_t     dec;

    assign in_ch.ready = (cnt_reg != CW'(QD));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign pop         = q_valid && q_ready;

    always_comb
    begin
        dec.p0_rn  = (in_ch.action == OP_MUL);
        dec.p1_en  = (in_ch.action == OP_ADD) || (in_ch.action == OP_SUB);
        dec.p1_sub = (in_ch.action == OP_SUB);
        dec.den_rn = (in_ch.action == OP_DIV);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_q[wr_ptr_reg] <= dec;
            ln_q[wr_ptr_reg]   <= in_ch.lhs_num;
            ld_q[wr_ptr_reg]   <= in_ch.lhs_den;
            rn_q[wr_ptr_reg]   <= in_ch.rhs_num;
            rd_q[wr_ptr_reg]   <= in_ch.rhs_den;
        end
    end

    assign q_ctrl = ctrl_q[rd_ptr_reg];
    assign q_ln   = ln_q[rd_ptr_reg];
    assign q_ld   = ld_q[rd_ptr_reg];
    assign q_rn   = rn_q[rd_ptr_reg];
    assign q_rd   = rd_q[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== rtl/rar_back.sv =====
// ============================================================================
// rar_back
// Forms the raw fraction with one shared multiplier, reduces it by a binary
// gcd and two restoring dividers, and holds the result beat.
// ============================================================================
`default_nettype none

module rar_back
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_valid,
    output logic                                 q_ready,
    input  wire rar_ctrl_t                       q_ctrl,
    input  wire logic signed [OPERAND_WIDTH-1:0] q_ln,
    input  wire logic signed [OPERAND_WIDTH-1:0] q_ld,
    input  wire logic signed [OPERAND_WIDTH-1:0] q_rn,
    input  wire logic signed [OPERAND_WIDTH-1:0] q_rd,
    rar_out_if.source                            out_ch
);

    localparam int PW = 2 * OPERAND_WIDTH;
    localparam int RW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
    localparam int KW = $clog2(RW);
    localparam int DW = $clog2(RW + 1);
    localparam int OW = RESULT_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_GCD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]                      state_reg, state_next;
    rar_ctrl_t                       ctrl_reg, ctrl_next;
    logic signed [OPERAND_WIDTH-1:0] ln_reg, ld_reg, rn_reg, rd_reg;
    logic signed [OPERAND_WIDTH-1:0] ln_next, ld_next, rn_next, rd_next;
    logic [1:0]                      mcnt_reg, mcnt_next;
    logic signed [PW-1:0]            prod_reg, prod_next;
    logic [RW-1:0]                   num_reg, num_next, den_reg, den_next;
    logic [RW-1:0]                   nm_reg, nm_next, dm_reg, dm_next;
    logic                            nneg_reg, nneg_next, dneg_reg, dneg_next;
    logic [RW-1:0]                   a_reg, a_next, b_reg, b_next;
    logic [KW-1:0]                   k_reg, k_next;
    logic [RW-1:0]                   g_reg, g_next;
    logic [RW-1:0]                   nq_reg, nq_next, dq_reg, dq_next;
    logic [RW:0]                     nr_reg, nr_next, dr_reg, dr_next;
    logic [DW-1:0]                   dcnt_reg, dcnt_next;
    logic                            ov_reg, ov_next;
    logic signed [OW-1:0]            rnum_reg, rnum_next, rden_reg, rden_next;
    logic                            rerr_reg, rerr_next;

    logic signed [OPERAND_WIDTH-1:0] ma, mb;
    logic [RW-1:0]                   prod_ext;
    logic [RW:0]                     nr_sh, dr_sh;
    logic [RW+OW-1:0]                nq_wide, dq_wide;
    logic [OW-1:0]                   nq_low, dq_low;
    logic                            out_free;

    assign q_ready  = (state_reg == S_IDLE);
    assign out_free = !ov_reg || out_ch.ready;
    assign prod_ext = RW'(prod_reg);

    // Operand pairs for the three products: numerator term, second
    // numerator term, denominator.
    always_comb
    begin
        unique case (mcnt_reg)
            2'd0:
            begin
                ma = ln_reg;
                mb = ctrl_reg.p0_rn ? rn_reg : rd_reg;
            end
            2'd1:
            begin
                ma = rn_reg;
                mb = ld_reg;
            end
            default:
            begin
                ma = ld_reg;
                mb = ctrl_reg.den_rn ? rn_reg : rd_reg;
            end
        endcase
    end

    assign nr_sh   = {nr_reg[RW-1:0], nq_reg[RW-1]};
    assign dr_sh   = {dr_reg[RW-1:0], dq_reg[RW-1]};
    assign nq_wide = {{OW{1'b0}}, nq_reg};
    assign dq_wide = {{OW{1'b0}}, dq_reg};
    assign nq_low  = nq_wide[OW-1:0];
    assign dq_low  = dq_wide[OW-1:0];

    always_comb
    begin
        state_next = state_reg;
        ctrl_next  = ctrl_reg;
        ln_next    = ln_reg;
        ld_next    = ld_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        mcnt_next  = mcnt_reg;
        prod_next  = prod_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        nm_next    = nm_reg;
        dm_next    = dm_reg;
        nneg_next  = nneg_reg;
        dneg_next  = dneg_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        nq_next    = nq_reg;
        dq_next    = dq_reg;
        nr_next    = nr_reg;
        dr_next    = dr_reg;
        dcnt_next  = dcnt_reg;
        ov_next    = ov_reg && !out_ch.ready;
        rnum_next  = rnum_reg;
        rden_next  = rden_reg;
        rerr_next  = rerr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    ctrl_next  = q_ctrl;
                    ln_next    = q_ln;
                    ld_next    = q_ld;
                    rn_next    = q_rn;
                    rd_next    = q_rd;
                    mcnt_next  = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next = PW'(ma) * PW'(mb);
                mcnt_next = mcnt_reg + 1'b1;
                unique case (mcnt_reg)
                    2'd0:
                    begin
                    end
                    2'd1:
                    begin
                        num_next = prod_ext;
                    end
                    2'd2:
                    begin
                        if (ctrl_reg.p1_en)
                        begin
                            num_next = ctrl_reg.p1_sub ? num_reg - prod_ext
                                                       : num_reg + prod_ext;
                        end
                    end
                    default:
                    begin
                        den_next   = prod_ext;
                        state_next = S_CHK;
                    end
                endcase
            end
            S_CHK:
            begin
                nneg_next = num_reg[RW-1];
                dneg_next = den_reg[RW-1];
                nm_next   = num_reg[RW-1] ? ~num_reg + 1'b1 : num_reg;
                dm_next   = den_reg[RW-1] ? ~den_reg + 1'b1 : den_reg;
                a_next    = nm_next;
                b_next    = dm_next;
                k_next    = '0;
                if (den_reg == '0)
                begin
                    // Zero quotients give the zero fields of the error beat.
                    nq_next    = '0;
                    dq_next    = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                // One binary gcd step per cycle; b stays nonzero throughout.
                priority if (a_reg == '0)
                begin
                    g_next     = b_reg << k_reg;
                    nq_next    = nm_reg;
                    dq_next    = dm_reg;
                    nr_next    = '0;
                    dr_next    = '0;
                    dcnt_next  = '0;
                    state_next = S_DIV;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (a_reg >= b_reg)
                begin
                    a_next = a_reg - b_reg;
                end
                else
                begin
                    b_next = b_reg - a_reg;
                end
            end
            S_DIV:
            begin
                if (nr_sh >= {1'b0, g_reg})
                begin
                    nr_next = nr_sh - {1'b0, g_reg};
                    nq_next = {nq_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    nr_next = nr_sh;
                    nq_next = {nq_reg[RW-2:0], 1'b0};
                end
                if (dr_sh >= {1'b0, g_reg})
                begin
                    dr_next = dr_sh - {1'b0, g_reg};
                    dq_next = {dq_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    dr_next = dr_sh;
                    dq_next = {dq_reg[RW-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DW'(RW - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    rnum_next  = nneg_reg ? -$signed(nq_low) : $signed(nq_low);
                    rden_next  = dneg_reg ? -$signed(dq_low) : $signed(dq_low);
                    rerr_next  = (den_reg == '0);
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            mcnt_reg  <= '0;
            dcnt_reg  <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            mcnt_reg  <= mcnt_next;
            dcnt_reg  <= dcnt_next;
            k_reg     <= k_next;
        end
    end

    // The result registers only change in states that hold no pending beat.
    always_ff @(posedge clk)
    begin
        ctrl_reg <= ctrl_next;
        ln_reg   <= ln_next;
        ld_reg   <= ld_next;
        rn_reg   <= rn_next;
        rd_reg   <= rd_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        nm_reg   <= nm_next;
        dm_reg   <= dm_next;
        nneg_reg <= nneg_next;
        dneg_reg <= dneg_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        g_reg    <= g_next;
        nq_reg   <= nq_next;
        dq_reg   <= dq_next;
        nr_reg   <= nr_next;
        dr_reg   <= dr_next;
        rnum_reg <= rnum_next;
        rden_reg <= rden_next;
        rerr_reg <= rerr_next;
    end

    assign out_ch.valid            = ov_reg;
    assign out_ch.result_num       = rnum_reg;
    assign out_ch.result_den       = rden_reg;
    assign out_ch.zero_denominator = rerr_reg;

endmodule

`default_nettype wire

// ===== rtl/rational_arithmetic_reduce.sv =====
// ============================================================================
// rational_arithmetic_reduce
// Adds, subtracts, multiplies or divides two fractions and reduces the
// result by its greatest common divisor.
// ============================================================================
// Usage:
// The in_ch channel takes one beat per operation: action and the two
// fractions. The out_ch channel gives one beat per operation, in order:
// reduced numerator and denominator, each keeping the sign the arithmetic
// gave it, or zeros with zero_denominator set when the raw denominator is 0.
// A two-entry queue lets up to two beats be taken while the back end works.
// The back end runs a gcd loop (one shift or subtract per cycle) and then
// two restoring dividers (one bit per cycle, run side by side) that give
// R-bit quotients, where R = min(2*OPERAND_WIDTH+1, 64). One operation is
// worked at a time. A zero raw denominator skips both.
// Reset empties the queue and drops any pending result. When the receiver
// stalls, the result beat holds in its output register, the back end waits
// with the next result, and the queue keeps taking beats until it is full.
// ============================================================================
`default_nettype none

module rational_arithmetic_reduce
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rar_in_if.sink    in_ch,
    rar_out_if.source out_ch
);

    logic                            q_valid;
    logic                            q_ready;
    rar_ctrl_t                       q_ctrl;
    logic signed [OPERAND_WIDTH-1:0] q_ln, q_ld, q_rn, q_rd;

    rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_ctrl  (q_ctrl),
        .q_ln    (q_ln),
        .q_ld    (q_ld),
        .q_rn    (q_rn),
        .q_rd    (q_rd)
    );

    rar_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_ctrl  (q_ctrl),
        .q_ln    (q_ln),
        .q_ld    (q_ld),
        .q_rn    (q_rn),
        .q_rd    (q_rd),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

// ===== rtl/rar_checker.sv =====
// ============================================================================
// rar_checker
// Port-level checks on the result channel of the rational arithmetic block.
// ============================================================================
`default_nettype none

module rar_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [32:0] out_num,
    input wire logic [32:0] out_den,
    input wire logic        out_zero
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_num) && $stable(out_den)
                                    && $stable(out_zero))
        else $error("result beat changed while stalled");

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_zero |-> out_num == '0 && out_den == '0)
        else $error("zero denominator beat carries nonzero fields");

    // A zero numerator reduces the denominator to its sign alone.
    a_zero_num: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_zero && out_num == '0
            |-> out_den == 33'd1 || out_den == {33{1'b1}})
        else $error("zero numerator not reduced to unit denominator");

endmodule

bind rational_arithmetic_reduce rar_checker u_rar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_num   (out_ch.result_num),
    .out_den   (out_ch.result_den),
    .out_zero  (out_ch.zero_denominator)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic testbench
// Drives fraction operations through the operand channel, takes the reduced
// result of each beat from the directed table or from reduce_fraction, and compares every result beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
    import rar_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1650;

    typedef struct packed {
        logic [1:0]   action;
        logic [W-1:0] lhs_num;
        logic [W-1:0] lhs_den;
        logic [W-1:0] rhs_num;
        logic [W-1:0] rhs_den;
    } fraction_op_t;

    typedef struct packed {
        logic [32:0] result_num;
        logic [32:0] result_den;
        logic        zero_denominator;
    } reduced_t;

    typedef struct packed {
        fraction_op_t op;
        logic         known;
        reduced_t     res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rar_in_if #(.OPERAND_WIDTH(W)) in_ch ();
    rar_out_if out_ch ();

    rational_arithmetic_reduce #(.OPERAND_WIDTH(W)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #6 clk = ~clk;

    reduced_t expected_q[$];
    int       mismatches = 0;
    int       send_idle_pct = 37;
    int       recv_idle_pct = 66;
    int       quiet_cycles = 0;
    bit       timed_out = 1'b0;

    function automatic logic [63:0] widen(logic [W-1:0] v);
        return {{(64-W){v[W-1]}}, v};
    endfunction

    function automatic logic [63:0] absval(logic [63:0] v);
        return v[63] ? 64'd0 - v : v;
    endfunction

    function automatic reduced_t reduce_fraction(fraction_op_t op);
        logic [63:0] ln, ld, rn, rd, num, den, a, b, r;
        reduced_t out;
        ln = widen(op.lhs_num);
        ld = widen(op.lhs_den);
        rn = widen(op.rhs_num);
        rd = widen(op.rhs_den);
        case (op.action)
            OP_ADD: begin num = ln * rd + rn * ld; den = ld * rd; end
            OP_SUB: begin num = ln * rd - rn * ld; den = ld * rd; end
            OP_MUL: begin num = ln * rn; den = ld * rd; end
            default: begin num = ln * rd; den = ld * rn; end
        endcase
        out = '0;
        if (den == 64'd0)
        begin
            out.zero_denominator = 1'b1;
            return out;
        end
        a = absval(num);
        b = absval(den);
        while (b != 64'd0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        r = absval(num) / a;
        out.result_num = num[63] ? 33'(64'd0 - r) : 33'(r);
        r = absval(den) / a;
        out.result_den = den[63] ? 33'(64'd0 - r) : 33'(r);
        return out;
    endfunction

    task automatic report_mismatch(string what, logic [32:0] got, logic [32:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what,
                 $signed(got), $signed(want), $realtime);
        mismatches++;
    endtask

    // Valid stays high across back-to-back beats; it drops only to idle.
    task automatic send_op(fraction_op_t op, reduced_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.action  <= op.action;
        in_ch.lhs_num <= op.lhs_num;
        in_ch.lhs_den <= op.lhs_den;
        in_ch.rhs_num <= op.rhs_num;
        in_ch.rhs_den <= op.rhs_den;
        expected_q.push_back(want);
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    function automatic logic [W-1:0] random_operand();
        case ($urandom_range(5))
            0: return W'($urandom_range(7)) - W'(3);
            1: return {1'b1, {(W-1){1'b0}}};
            2: return {1'b0, {(W-1){1'b1}}};
            3: return W'($urandom_range(60)) * W'($urandom_range(12) + 1);
            default: return W'($urandom);
        endcase
    endfunction

    // Result side: random stalls on ready and in-order checking.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("unexpected result beat", out_ch.result_num, '0);
                end
                else
                begin
                    reduced_t want;
                    want = expected_q.pop_front();
                    if (out_ch.result_num !== want.result_num)
                        report_mismatch("result_num", out_ch.result_num, want.result_num);
                    if (out_ch.result_den !== want.result_den)
                        report_mismatch("result_den", out_ch.result_den, want.result_den);
                    if (out_ch.zero_denominator !== want.zero_denominator)
                        report_mismatch("zero_denominator", 33'(out_ch.zero_denominator),
                                        33'(want.zero_denominator));
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
        else
        begin
            out_ch.ready <= 1'b0;
        end
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("Mismatches found");
            $finish;
        end
    end

    localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE  = W'(1);
    localparam logic [W-1:0] ZERO = '0;
    localparam logic [W-1:0] NEG1 = '1;

    stim_row_t directed[] = '{
        // Zero raw denominator flags the error and zeroes the outputs.
        '{'{OP_ADD, ONE, ZERO, ONE, ONE}, 1'b1, '{33'd0, 33'd0, 1'b1}},
        '{'{OP_SUB, ONE, ONE, ONE, ZERO}, 1'b1, '{33'd0, 33'd0, 1'b1}},
        '{'{OP_MUL, MAXP, ZERO, MAXP, ZERO}, 1'b1, '{33'd0, 33'd0, 1'b1}},
        '{'{OP_DIV, ONE, ONE, ZERO, ONE}, 1'b1, '{33'd0, 33'd0, 1'b1}},
        // Zero raw numerator reduces to 0 over a unit with the sign kept; then small unit operands.
        '{'{OP_MUL, ZERO, W'(6), W'(5), W'(4)}, 1'b1, '{33'd0, 33'd1, 1'b0}},
        '{'{OP_MUL, ZERO, NEG1, W'(5), W'(4)}, 1'b1, '{33'd0, '1, 1'b0}},
        '{'{OP_ADD, ONE, ONE, ONE, ONE}, 1'b1, '{33'd2, 33'd1, 1'b0}},
        '{'{OP_SUB, ONE, ONE, ONE, ONE}, 1'b1, '{33'd0, 33'd1, 1'b0}},
        '{'{OP_DIV, NEG1, ONE, ONE, ONE}, 1'b1, '{'1, 33'd1, 1'b0}},
        // Extremes of the operand range, then small mixed-sign fractions.
        '{'{OP_MUL, MINN, ONE, MINN, ONE}, 1'b1, '{33'd1073741824, 33'd1, 1'b0}},
        '{'{OP_MUL, MINN, NEG1, MINN, NEG1}, 1'b0, '0},
        '{'{OP_ADD, MINN, MAXP, MINN, MAXP}, 1'b0, '0},
        '{'{OP_SUB, MINN, MAXP, MAXP, MINN}, 1'b0, '0},
        '{'{OP_ADD, MAXP, MINN, MAXP, MINN}, 1'b0, '0},
        '{'{OP_DIV, MAXP, MINN, MINN, MAXP}, 1'b0, '0},
        '{'{OP_DIV, MINN, MINN, MINN, MINN}, 1'b0, '0},
        '{'{OP_SUB, MINN, NEG1, MAXP, ONE}, 1'b0, '0},
        '{'{OP_ADD, W'(6), W'(-4), W'(-10), W'(12)}, 1'b0, '0},
        '{'{OP_DIV, W'(-9), W'(21), W'(15), W'(-35)}, 1'b0, '0},
        '{'{OP_MUL, W'(12), W'(-18), W'(-27), W'(8)}, 1'b0, '0}
    };

    initial
    begin
        fraction_op_t op;
        in_ch.valid   <= 1'b0;
        in_ch.action  <= OP_ADD;
        in_ch.lhs_num <= '0;
        in_ch.lhs_den <= '0;
        in_ch.rhs_num <= '0;
        in_ch.rhs_den <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_op(directed[i].op, directed[i].known ? directed[i].res
                                                      : reduce_fraction(directed[i].op));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Receiver-heavy idling first, then sender-heavy, then none.
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 37;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            op.action  = 2'($urandom_range(3));
            op.lhs_num = random_operand();
            op.lhs_den = random_operand();
            op.rhs_num = random_operand();
            op.rhs_den = random_operand();
            send_op(op, reduce_fraction(op));
        end
        in_ch.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/rar_pkg.sv
rtl/rar_if.sv
rtl/rar_front.sv
rtl/rar_back.sv
rtl/rational_arithmetic_reduce.sv
rtl/rar_checker.sv
verif/testbench.sv
